// ----- sv/ddpi_pkg.sv -----
// Shared constants, widths and the CORDIC arctangent table for the pose integrator.
package ddpi_pkg;

  localparam int SPEED_MAX     = 255;
  localparam int SPEED_W       = 9;
  localparam int CORDIC_STEPS  = 16;
  localparam int CORDIC_IDX_W  = $clog2(CORDIC_STEPS + 1);
  localparam int CORDIC_W      = 20;
  localparam int CORDIC_GAIN   = 19898;
  localparam int LATCH_TOP     = 3;

  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [2:0] REG_STEP   = 3'd0;
  localparam logic [2:0] REG_TURN   = 3'd1;
  localparam logic [2:0] REG_TICKS  = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;

  // arctangent of 2^-i in 32 bit binary angle units
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/diff_drive_pose_integrator.sv -----
// Top level: configuration registers, command arbitration and tick sequencer.
//
// Input stream (s_t*): one transaction per item. s_tuser is the mode
// (0 motor command, 1 time tick); s_tdata carries the command fields.
// Output stream (m_t*): one transaction per input item with the pose,
// heading, four encoder counts and the wall flag, all after the item.
// Configuration: APB port, five registers at byte addresses 0, 4 .. 16;
// write only while the block is idle.
// A command item gives its result in the cycle after acceptance. A tick
// item runs eight products through one shared 31x21 multiplier (encoders,
// distance, turn, then x and y moves), each with a multiply and an
// accumulate state, and waits on the iterative CORDIC, 16 rotation steps
// plus the done hand-over, between the turn and the x move.
// One item is worked at a time; s_tready is low from acceptance until the
// result transaction completes, so a stalled receiver holds the block.
// Reset clears pose, heading, encoders, wheel speeds and the arbitration
// latch, sets the canvas limits to all ones and the other registers to zero.
module diff_drive_pose_integrator
  import ddpi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // remote-control flag, set_front_left, set_front_right, set_back_left,
  // set_back_right, speed_front_left, speed_front_right, speed_back_left,
  // speed_back_right
  input  logic [47:0]  s_tdata,
  // mode
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, heading, enc_front_left, enc_front_right, enc_back_left,
  // enc_back_right, hit_wall
  output logic [215:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_CWAIT = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [2:0] OP_LIN  = 3'd4;
  localparam logic [2:0] OP_TURN = 3'd5;
  localparam logic [2:0] OP_X    = 3'd6;
  localparam logic [2:0] OP_Y    = 3'd7;

  logic [2:0]  state;
  logic [2:0]  opi;

  logic [19:0] step_per_speed;
  logic [15:0] turn_per_speed;
  logic [15:0] ticks_per_speed;
  logic [31:0] width_limit;
  logic [31:0] height_limit;

  logic signed [SPEED_W-1:0] wheel_speed [4];
  logic [31:0]               encoder_count [4];
  logic [1:0]                latch_count;
  logic [31:0]               position_x;
  logic [31:0]               position_y;
  logic [15:0]               heading_angle;
  logic                      hit;
  logic signed [MUL_A_W-1:0] lin;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic                       cordic_start;
  logic                       cordic_done;
  logic signed [CORDIC_W-1:0] cos_v;
  logic signed [CORDIC_W-1:0] sin_v;

  logic signed [SPEED_W:0]   left_sum;
  logic signed [SPEED_W:0]   right_sum;
  logic signed [SPEED_W+1:0] all_sum;
  logic signed [SPEED_W+1:0] diff_sum;

  logic                      cfg_wr;
  logic                      in_acc;
  logic                      teleop;
  logic                      accept_cmd;
  logic [1:0]                latch_up;
  logic [1:0]                latch_next;
  logic signed [PROD_W-1:0]  move;
  logic signed [PROD_W-1:0]  nxy;
  logic [31:0]               lim;
  logic [31:0]               cur;
  logic [31:0]               clamped;
  logic                      wall;

  // truncate toward zero on a power-of-two division
  function automatic logic signed [PROD_W-1:0] div_trunc(
    input logic signed [PROD_W-1:0] p, input int unsigned k);
    logic signed [PROD_W-1:0] bias;
    bias = p[PROD_W-1] ? (PROD_W'(1) << k) - PROD_W'(1) : '0;
    return (p + bias) >>> k;
  endfunction

  function automatic logic signed [SPEED_W-1:0] sat_speed(input logic [SPEED_W-1:0] s);
    logic signed [SPEED_W-1:0] v;
    v = $signed(s);
    if (v < -SPEED_W'(SPEED_MAX)) return -SPEED_W'(SPEED_MAX);
    if (v > SPEED_W'(SPEED_MAX)) return SPEED_W'(SPEED_MAX);
    return v;
  endfunction

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_per_speed  <= '0;
      turn_per_speed  <= '0;
      ticks_per_speed <= '0;
      width_limit     <= '1;
      height_limit    <= '1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_STEP:   step_per_speed  <= pwdata[19:0];
        REG_TURN:   turn_per_speed  <= pwdata[15:0];
        REG_TICKS:  ticks_per_speed <= pwdata[15:0];
        REG_WIDTH:  width_limit     <= pwdata;
        REG_HEIGHT: height_limit    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_STEP:   prdata = {12'h0, step_per_speed};
      REG_TURN:   prdata = {16'h0, turn_per_speed};
      REG_TICKS:  prdata = {16'h0, ticks_per_speed};
      REG_WIDTH:  prdata = width_limit;
      REG_HEIGHT: prdata = height_limit;
      default:    prdata = '0;
    endcase
  end

  // wheel sums
  assign left_sum  = (SPEED_W+1)'(wheel_speed[0]) + (SPEED_W+1)'(wheel_speed[2]);
  assign right_sum = (SPEED_W+1)'(wheel_speed[1]) + (SPEED_W+1)'(wheel_speed[3]);
  assign all_sum   = (SPEED_W+2)'(left_sum) + (SPEED_W+2)'(right_sum);
  assign diff_sum  = (SPEED_W+2)'(right_sum) - (SPEED_W+2)'(left_sum);

  // shared multiplier operand select
  always_comb begin
    case (opi)
      OP_LIN: begin
        mul_a = MUL_A_W'(all_sum);
        mul_b = $signed({1'b0, step_per_speed});
      end
      OP_TURN: begin
        mul_a = MUL_A_W'(diff_sum);
        mul_b = $signed({5'b0, turn_per_speed});
      end
      OP_X: begin
        mul_a = lin;
        mul_b = MUL_B_W'(cos_v);
      end
      OP_Y: begin
        mul_a = lin;
        mul_b = MUL_B_W'(sin_v);
      end
      default: begin
        mul_a = MUL_A_W'(wheel_speed[opi[1:0]]);
        mul_b = $signed({5'b0, ticks_per_speed});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // command arbitration
  assign in_acc     = s_tvalid & s_tready;
  assign teleop     = s_tdata[0];
  assign latch_up   = (!teleop && latch_count != 2'(LATCH_TOP)) ? latch_count + 2'd1
                                                                  : latch_count;
  assign accept_cmd = !teleop || latch_up == 2'd0;
  assign latch_next = (teleop && latch_up != 2'd0) ? latch_up - 2'd1 : latch_up;

  // position move and clamp for the x or y step
  assign move = prod >>> 15;
  assign lim  = (opi == OP_X) ? width_limit : height_limit;
  assign cur  = (opi == OP_X) ? position_x : position_y;
  assign nxy  = (opi == OP_X) ? $signed({20'h0, cur}) + move
                              : $signed({20'h0, cur}) - move;
  always_comb begin
    wall    = 1'b0;
    clamped = nxy[31:0];
    if (nxy[PROD_W-1]) begin
      wall    = 1'b1;
      clamped = '0;
    end else if (nxy >= $signed({20'h0, lim})) begin
      wall    = 1'b1;
      clamped = lim;
    end
  end

  assign cordic_start = (state == S_ACC) && (opi == OP_TURN);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      opi           <= '0;
      latch_count   <= '0;
      position_x    <= '0;
      position_y    <= '0;
      heading_angle <= '0;
      hit           <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        wheel_speed[k]   <= '0;
        encoder_count[k] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            hit <= 1'b0;
            if (!s_tuser) begin
              latch_count <= latch_next;
              if (accept_cmd) begin
                for (int k = 0; k < 4; k++) begin
                  if (s_tdata[1+k]) begin
                    wheel_speed[k] <= sat_speed(s_tdata[5+SPEED_W*k +: SPEED_W]);
                  end
                end
              end
              state <= S_OUT;
            end else begin
              opi   <= '0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          case (opi)
            OP_LIN:  lin <= MUL_A_W'(div_trunc(prod, 2));
            OP_TURN: heading_angle <= heading_angle + 16'(div_trunc(prod, 1));
            OP_X: begin
              position_x <= clamped;
              hit        <= hit | wall;
            end
            OP_Y: begin
              position_y <= clamped;
              hit        <= hit | wall;
            end
            default: encoder_count[opi[1:0]] <=
                       encoder_count[opi[1:0]] + 32'(div_trunc(prod, 8));
          endcase
          if (opi == OP_TURN) begin
            state <= S_CWAIT;
          end else if (opi == OP_Y) begin
            state <= S_OUT;
          end else begin
            opi   <= opi + 3'd1;
            state <= S_MUL;
          end
        end
        S_CWAIT: begin
          if (cordic_done) begin
            opi   <= OP_X;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ddpi_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .angle   (heading_angle + 16'(div_trunc(prod, 1))),
    .done    (cordic_done),
    .cos_out (cos_v),
    .sin_out (sin_v)
  );

  // output
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {7'h0, hit, encoder_count[3], encoder_count[2], encoder_count[1],
                     encoder_count[0], heading_angle, position_y, position_x};

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input and output open together");
  a_cmd_fast: assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready && !s_tuser) |=> (m_tvalid && !m_tdata[208]))
    else $error("command result late or flags a wall");
  a_cordic_wait: assert property (@(posedge clk) disable iff (rst)
      cordic_done |-> state == S_CWAIT)
    else $error("cordic result outside wait state");
`endif

endmodule

// ----- sv/ddpi_cordic.sv -----
// Iterative CORDIC: one rotation step per cycle, cosine and sine in signed Q4.15.
module ddpi_cordic
  import ddpi_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [15:0]                angle,
  output logic                       done,
  output logic signed [CORDIC_W-1:0] cos_out,
  output logic signed [CORDIC_W-1:0] sin_out
);

  logic                       busy;
  logic                       flip;
  logic [CORDIC_IDX_W-1:0]    idx;
  logic signed [CORDIC_W-1:0] x;
  logic signed [CORDIC_W-1:0] y;
  logic [31:0]                z;
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic                       flip_in;
  logic [15:0]                ang_in;

  // fold the left half plane onto the right one
  assign flip_in = angle[14] ^ angle[15];
  assign ang_in  = flip_in ? angle + 16'h8000 : angle;

  assign xs = x >>> idx;
  assign ys = y >>> idx;

  // run the rotation steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
        flip <= flip_in;
        x    <= CORDIC_W'(CORDIC_GAIN);
        y    <= '0;
        z    <= {ang_in, 16'h0};
      end else if (busy) begin
        if (!z[31]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_turn(5'(idx));
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_turn(5'(idx));
        end
        idx <= idx + 1'b1;
        if (idx == CORDIC_IDX_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign cos_out = flip ? -x : x;
  assign sin_out = flip ? -y : y;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) busy |-> !start)
    else $error("cordic restarted while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("cordic done while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("cordic did not start");
`endif

endmodule
